### sv/utf8_to_gbk_transcoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 to GBK transcoder assertion macros
// Shared property wrappers for the transcoder; all sample on clk and are
// switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_GBK_TRANSCODER_MACROS_SVH
`define UTF8_TO_GBK_TRANSCODER_MACROS_SVH

// Same-cycle implication.
`define U2G_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define U2G_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/u2g_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to GBK transcoder package
// Types, codes and constants shared by the transcoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package u2g_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int CNT_W   = 7;   // table_count register
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;   // entry_index field
  localparam int CODE_W  = 16;
  localparam int GBK_W   = 16;
  localparam int ENTRY_W = CODE_W + GBK_W;
  localparam int IN_DATA_W = 48; // 8 + 6 + 16 + 16 = 46, padded to bytes

  // Operation codes carried in the input tuser bit.
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // UTF-8 byte classes.
  localparam logic [1:0] CONT_TAG  = 2'b10;  // 10xxxxxx
  localparam logic [3:0] LEAD3_TAG = 4'hE;   // 1110xxxx

  // Pending byte counts.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_LEAD = 2'd1;
  localparam logic [1:0] PEND_MID  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_EMIT_A,
    S_EMIT_B
  } u2g_state_t;

endpackage

`default_nettype wire

### sv/utf8_to_gbk_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to GBK transcoder
// Converts a NUL-terminated UTF-8 byte stream to GBK using a loadable,
// sorted mapping table searched by bisection.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake            Carries
//   in_      in   in_tvalid/in_tready  tuser: operation; tdata: text byte,
//                                      table slot, code point, GBK code
//   out_     out  out_tvalid/out_tready tdata: output byte; tuser: end of
//                                      text; tlast: last item of the input
//   cfg_     in   cfg_valid/cfg_ready  table_count (always ready)
//
// A table write, or a text byte that only extends a pending sequence, is
// taken in S_IDLE without leaving it. An ASCII byte or a terminator passes
// through S_EMIT_A. A completed three-byte character takes P bisection probes
// and then S_EMIT_A and S_EMIT_B when its code point is found, or returns to
// S_IDLE when it is not; P is at most 7 for 64 entries. Each probe is one
// table RAM read followed by one compare on the single shared comparator.
// Reset is synchronous and active low; it clears the sequencer, the pending
// UTF-8 state and table_count. The table RAM is not cleared and is undefined
// until written. A stalled output holds its item in the output register while
// the sequencer waits in an emit state; the input is taken only when idle.
//
`default_nettype none

module utf8_to_gbk_transcoder #(
  parameter int TABLE_DEPTH = u2g_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input items.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [u2g_pkg::IN_DATA_W-1:0]  in_tdata,  // in_byte[7:0], entry_index[13:8],
                                                         // entry_code[29:14],
                                                         // entry_gbk[45:30], zero
  input  wire logic                           in_tuser,  // operation[0]
  // Result items.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [u2g_pkg::BYTE_W-1:0]          out_tdata, // out_byte[7:0]
  output logic                                out_tuser, // end_of_text[0]
  output logic                                out_tlast, // run_end
  // Configuration.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [u2g_pkg::CNT_W-1:0]      cfg_data   // table_count[6:0]
);

  import u2g_pkg::*;

  `include "utf8_to_gbk_transcoder_macros.svh"

  // Address width of the table and width of the search bounds, which must
  // hold TABLE_DEPTH itself.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Unpack the input item.
  logic [BYTE_W-1:0] in_byte;
  logic [IDX_W-1:0]  in_entry_index;
  logic [CODE_W-1:0] in_entry_code;
  logic [GBK_W-1:0]  in_entry_gbk;

  assign in_byte        = in_tdata[7:0];
  assign in_entry_index = in_tdata[13:8];
  assign in_entry_code  = in_tdata[29:14];
  assign in_entry_gbk   = in_tdata[45:30];

  // Registers.
  u2g_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [1:0]        pend_r, pend_nxt;
  logic [3:0]        lead_r, lead_nxt;
  logic [5:0]        midb_r, midb_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [GBK_W-1:0]  emit_r, emit_nxt;
  logic              two_r, two_nxt;
  logic              eot_r, eot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_eot_r, out_eot_nxt;
  logic              out_last_r, out_last_nxt;

  // Handshakes and decoded conditions.
  logic              in_fire;
  logic              out_free;
  logic              is_cont;
  logic [CW-1:0]     limit;
  logic [CW:0]       bound_sum;
  logic [CW-1:0]     probe;
  logic [ENTRY_W-1:0] rd_data;
  logic [CODE_W-1:0] probe_code;
  logic              wr_en;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign is_cont   = (in_byte[7:6] == CONT_TAG);

  // Number of entries searched: table_count capped at the table depth.
  assign limit = (32'(count_r) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_r);

  // Midpoint of the current bounds; below hi while lo < hi, so it fits the address.
  assign bound_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign probe      = bound_sum[CW:1];
  assign probe_code = rd_data[ENTRY_W-1:GBK_W];

  // Table writes beyond the depth are ignored.
  assign wr_en = in_fire && (in_tuser == OP_WRITE) &&
                 (32'(in_entry_index) < 32'(TABLE_DEPTH));

  u2g_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data ({in_entry_code, in_entry_gbk}),
    .rd_en   (state_r == S_SRCH),
    .rd_addr (AW'(probe)),
    .rd_data (rd_data)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser == OP_CONVERT)) begin
          if (pend_r == PEND_MID && is_cont) begin
            state_nxt = S_SRCH;
          end else if (pend_r == PEND_LEAD && is_cont) begin
            state_nxt = S_IDLE;
          end else if (!in_byte[7]) begin
            // ASCII or terminator, possibly after a broken sequence.
            state_nxt = S_EMIT_A;
          end
        end
      end
      S_SRCH: begin
        state_nxt = (lo_r < hi_r) ? S_CMP : S_IDLE;
      end
      S_CMP: begin
        state_nxt = (probe_code == code_r) ? S_EMIT_A : S_SRCH;
      end
      S_EMIT_A: begin
        if (out_free) begin
          state_nxt = two_r ? S_EMIT_B : S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    pend_nxt      = pend_r;
    lead_nxt      = lead_r;
    midb_nxt      = midb_r;
    code_nxt      = code_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    emit_nxt      = emit_r;
    two_nxt       = two_r;
    eot_nxt       = eot_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_eot_nxt   = out_eot_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser == OP_CONVERT)) begin
          if (pend_r == PEND_LEAD && is_cont) begin
            midb_nxt = in_byte[5:0];
            pend_nxt = PEND_MID;
          end else if (pend_r == PEND_MID && is_cont) begin
            pend_nxt = PEND_NONE;
            code_nxt = {lead_r, midb_r, in_byte[5:0]};
            lo_nxt   = '0;
            hi_nxt   = limit;
          end else begin
            // Nothing pending from here on; the byte stands on its own.
            pend_nxt = PEND_NONE;
            if (!in_byte[7]) begin
              emit_nxt = {{(GBK_W-BYTE_W){1'b0}}, in_byte};
              two_nxt  = 1'b0;
              eot_nxt  = (in_byte == '0);
            end else if (in_byte[7:4] == LEAD3_TAG) begin
              lead_nxt = in_byte[3:0];
              pend_nxt = PEND_LEAD;
            end
          end
        end
      end
      S_SRCH: begin
        mid_nxt = probe;
      end
      S_CMP: begin
        // The one compare unit of the search.
        if (probe_code < code_r) begin
          lo_nxt = mid_r + CW'(1);
        end else if (probe_code > code_r) begin
          hi_nxt = mid_r;
        end else begin
          emit_nxt = rd_data[GBK_W-1:0];
          two_nxt  = 1'b1;
          eot_nxt  = 1'b0;
        end
      end
      S_EMIT_A: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = two_r ? emit_r[15:8] : emit_r[7:0];
          out_eot_nxt   = eot_r;
          out_last_nxt  = !two_r;
        end
      end
      S_EMIT_B: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_r[7:0];
          out_eot_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_tready;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= PEND_NONE;
      lead_r      <= '0;
      midb_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      lead_r      <= lead_nxt;
      midb_r      <= midb_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    code_r     <= code_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    emit_r     <= emit_nxt;
    two_r      <= two_nxt;
    eot_r      <= eot_nxt;
    out_byte_r <= out_byte_nxt;
    out_eot_r  <= out_eot_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_eot_r;
  assign out_tlast  = out_last_r;

  // A compare only ever follows a probe taken inside non-empty bounds.
  `U2G_ASSERT_NOW(a_cmp_bounds, state_r == S_CMP, mid_r < hi_r && mid_r >= lo_r, "probe outside bounds")
  // The pending count never takes its unused code.
  `U2G_ASSERT_NOW(a_pend_code, 1'b1, pend_r != 2'd3, "pending count out of range")
  // The second GBK byte always closes the run of the input.
  `U2G_ASSERT_NEXT(a_emit_last, state_r == S_EMIT_B && out_free, out_tvalid && out_tlast && !out_tuser, "second byte not marked last")
  // The first GBK byte of a pair is never marked last.
  `U2G_ASSERT_NEXT(a_emit_first, state_r == S_EMIT_A && out_free && two_r, out_tvalid && !out_tlast, "first byte marked last")

endmodule

`default_nettype wire

### sv/u2g_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module u2g_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### verif/gbk_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GBK stream checker
// Follows the transcoder's input, result and table_count channels, predicts
// the bytes that each accepted input item should produce and compares them,
// in order, with the result items leaving the block.
// ----------------------------------------------------------------------------
module gbk_stream_checker #(
  parameter int DEPTH = u2g_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [u2g_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [u2g_pkg::BYTE_W-1:0]    out_tdata,
  input  logic                          out_tuser,
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [u2g_pkg::CNT_W-1:0]     cfg_data,
  output int                            fault_total,
  output int                            awaited_total
);
  import u2g_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              eot;
    logic              run_end;
  } gbk_item_t;

  logic [CODE_W-1:0] code_map [DEPTH];
  logic [GBK_W-1:0]  gbk_map  [DEPTH];
  logic [1:0]        pend;
  logic [3:0]        lead_nib;
  logic [5:0]        mid_six;
  logic [CNT_W-1:0]  searched;
  gbk_item_t         awaited [$];
  gbk_item_t         want;

  function automatic void await_byte(input logic [7:0] v, input logic eot, input logic fin);
    awaited.push_back(gbk_item_t'({v, eot, fin}));
  endfunction

  // Bisection over the first table_count slots, clamped to the table size.
  function automatic bit find_gbk(input logic [15:0] cp, output logic [15:0] gbk);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = (searched > DEPTH) ? DEPTH : int'(searched);
    gbk = '0;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (code_map[mid] < cp) begin
        lo = mid + 1;
      end else if (code_map[mid] > cp) begin
        hi = mid;
      end else begin
        gbk = gbk_map[mid];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // A byte seen with nothing pending.
  function automatic void fresh_byte(input logic [7:0] b);
    if (b == 8'h00) begin
      await_byte(8'h00, 1'b1, 1'b1);
    end else if (!b[7]) begin
      await_byte(b, 1'b0, 1'b1);
    end else if (b[7:4] == LEAD3_TAG) begin
      lead_nib = b[3:0];
      pend = PEND_LEAD;
    end
  endfunction

  function automatic void predict_item(input logic op, input logic [IN_DATA_W-1:0] d);
    logic [7:0]  b;
    logic        cont;
    logic [15:0] cp;
    logic [15:0] gbk;
    b = d[7:0];
    cont = (b[7:6] == CONT_TAG);
    if (op == OP_WRITE) begin
      if (int'(d[13:8]) < DEPTH) begin
        code_map[d[13:8]] = d[29:14];
        gbk_map[d[13:8]] = d[45:30];
      end
    end else if (pend == PEND_LEAD) begin
      pend = PEND_NONE;
      if (cont) begin
        mid_six = b[5:0];
        pend = PEND_MID;
      end else begin
        fresh_byte(b);
      end
    end else if (pend == PEND_MID) begin
      pend = PEND_NONE;
      if (!cont) begin
        fresh_byte(b);
      end else begin
        cp = {lead_nib, mid_six, b[5:0]};
        if (find_gbk(cp, gbk)) begin
          await_byte(gbk[15:8], 1'b0, 1'b0);
          await_byte(gbk[7:0], 1'b0, 1'b1);
        end
      end
    end else begin
      pend = PEND_NONE;
      fresh_byte(b);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pend = PEND_NONE;
      lead_nib = '0;
      mid_six = '0;
      searched = '0;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        searched = cfg_data;
      end
      // A result can never leave at the edge that takes its own input item.
      if (out_tvalid && out_tready) begin
        if (awaited.size() == 0) begin
          fault_total++;
          if (fault_total <= REPORT_LIMIT) begin
            $display("%0t: result byte %h eot %b last %b with nothing awaited",
                     $time, out_tdata, out_tuser, out_tlast);
          end
        end else begin
          want = awaited.pop_front();
          if ({out_tdata, out_tuser, out_tlast} !== want) begin
            fault_total++;
            if (fault_total <= REPORT_LIMIT) begin
              $display("%0t: expected byte %h eot %b last %b, got byte %h eot %b last %b",
                       $time, want.value, want.eot, want.run_end,
                       out_tdata, out_tuser, out_tlast);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_item(in_tuser, in_tdata);
      end
    end
    awaited_total = awaited.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 to GBK transcoder testbench
// Loads the mapping table, runs a short directed sequence and then random
// text under several table_count settings and idling patterns, while a
// separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import u2g_pkg::*;

  localparam int SLOTS        = TABLE_DEPTH_DEF;
  localparam int PHASE_ITEMS  = 260;
  localparam int DRAIN_CYCLES = 40;
  localparam int NO_SPLIT     = -1;
  // Around 1700 items, with sender gaps and receiver stalls, stay well below
  // this limit.
  localparam int CYCLE_LIMIT  = 500000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic                 in_tuser = OP_CONVERT;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [BYTE_W-1:0]    out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data = '0;

  int fault_total;
  int awaited_total;
  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  // Code points currently held in each slot, so that random text can aim at
  // entries that exist.
  logic [CODE_W-1:0] slot_code [SLOTS];

  utf8_to_gbk_transcoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  gbk_stream_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fault_total   (fault_total),
    .awaited_total (awaited_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random, one decision per cycle.
  always @(negedge clk) begin
    out_tready <= (32'($urandom_range(99)) >= sink_idle_pct);
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_to_gbk_transcoder: mismatch");
      $finish;
    end
  end

  // Three bytes of the UTF-8 form of a 16-bit code point.
  function automatic logic [7:0] char_byte(input logic [15:0] cp, input int k);
    case (k)
      0:       return {LEAD3_TAG, cp[15:12]};
      1:       return {CONT_TAG, cp[11:6]};
      default: return {CONT_TAG, cp[5:0]};
    endcase
  endfunction

  // Presents one item from a falling edge and holds it until it is taken. The
  // sender may idle first; valid stays high when items follow back to back.
  task automatic send_item(input logic op, input logic [7:0] text, input logic [5:0] slot,
                           input logic [15:0] cp, input logic [15:0] gbk);
    while (32'($urandom_range(99)) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, gbk, cp, slot, text};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // The fields that an operation ignores still carry random bits.
  task automatic send_text(input logic [7:0] b);
    send_item(OP_CONVERT, b, 6'($urandom_range(63)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)));
  endtask

  task automatic send_entry(input logic [5:0] slot, input logic [15:0] cp,
                            input logic [15:0] gbk);
    send_item(OP_WRITE, 8'($urandom_range(255)), slot, cp, gbk);
  endtask

  // New GBK code for a slot; the code point is kept so the order holds.
  task automatic rewrite_entry(input logic [5:0] slot);
    send_entry(slot, slot_code[slot], 16'($urandom_range(65535)));
  endtask

  // A whole character, optionally with a table write slipped in before byte
  // write_at, which must leave the pending bytes alone.
  task automatic send_char(input logic [15:0] cp, input int write_at, input logic [5:0] slot);
    for (int k = 0; k < 3; k++) begin
      if (k == write_at) begin
        rewrite_entry(slot);
      end
      send_text(char_byte(cp, k));
    end
  endtask

  // Fills every slot. A sorted table starts at code 0, ends at 0xFFFF and
  // steps by at least two, so the code after slot 1 is certain to be absent.
  // Slot 1 has a zero high GBK byte and the last slot a zero low byte.
  task automatic load_table(input bit sorted);
    logic [15:0] cp;
    logic [15:0] gbk;
    cp = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!sorted) begin
        cp = 16'($urandom_range(65535));
      end else if (s == SLOTS - 1) begin
        cp = 16'hFFFF;
      end else if (s > 0) begin
        cp = cp + 16'($urandom_range(1000, 2));
      end
      gbk = 16'($urandom_range(65535));
      if (sorted && s == 1) begin
        gbk[15:8] = 8'h00;
      end else if (sorted && s == SLOTS - 1) begin
        gbk[7:0] = 8'h00;
      end
      slot_code[s] = cp;
      send_entry(6'(s), cp, gbk);
    end
  endtask

  // Waits until every predicted result has left, then lets a search that
  // ends in a miss run out as well. Called at a falling edge, valid low.
  task automatic settle();
    while (awaited_total != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_count(input logic [CNT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed text with random content, the rest table rewrites,
  // broken sequences and raw noise.
  task automatic random_burst(input int n);
    int         stop;
    int         pick;
    logic [7:0] b;
    stop = items_sent + n;
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_char(slot_code[$urandom_range(SLOTS - 1)], NO_SPLIT, '0);
      end else if (pick < 45) begin
        send_char(16'($urandom_range(65535)), NO_SPLIT, '0);
      end else if (pick < 50) begin
        send_char(slot_code[$urandom_range(SLOTS - 1)], $urandom_range(2, 1),
                  6'($urandom_range(SLOTS - 1)));
      end else if (pick < 68) begin
        send_text(8'($urandom_range(127, 1)));
      end else if (pick < 73) begin
        send_text(8'h00);
      end else if (pick < 80) begin
        rewrite_entry(6'($urandom_range(SLOTS - 1)));
      end else if (pick < 88) begin
        // A lead byte, perhaps its middle byte, then something that is not a
        // continuation byte and so breaks the sequence.
        send_text(char_byte(16'($urandom_range(65535)), 0));
        if ($urandom_range(1) == 1) begin
          send_text(char_byte(16'($urandom_range(65535)), 1));
        end
        b = 8'($urandom_range(255));
        if (b[7:6] == CONT_TAG) begin
          b[6] = 1'b1;
        end
        send_text(b);
      end else begin
        send_text(8'($urandom_range(255)));
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] count_setting;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 11;
    sink_idle_pct = 45;
    set_count(CNT_W'(SLOTS));
    load_table(1'b1);

    // Directed part: ASCII extremes and the terminator.
    send_text(8'h41);
    send_text(8'h7F);
    send_text(8'h00);
    // Lowest and highest code points, sitting in the first and last slots;
    // the latter also gives a zero low GBK byte.
    send_char(16'h0000, NO_SPLIT, '0);
    send_char(16'hFFFF, NO_SPLIT, '0);
    // Zero high GBK byte, then a code point that is not in the table.
    send_char(slot_code[1], NO_SPLIT, '0);
    send_char(slot_code[1] + 16'd1, NO_SPLIT, '0);
    // Stray bytes: a lone continuation, 0xFF, two- and four-byte leads.
    send_text(8'h80);
    send_text(8'hFF);
    send_text(8'hC3);
    send_text(8'hF0);
    // Broken after the lead byte: the ASCII byte still comes out.
    send_text(8'hE4);
    send_text(8'h41);
    // Broken after the middle byte by a zero, which ends the string.
    send_text(8'hE4);
    send_text(8'hB8);
    send_text(8'h00);
    // A table write between lead and middle byte changes the code found.
    send_char(slot_code[5], 1, 6'd5);
    in_tvalid <= 1'b0;

    // Random phases: settings of table_count including both ends of the
    // register and a value above the table size, the last on an unsorted
    // table. Idling moves from the receiver to the sender, then stops.
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 11 : (p < 4) ? 45 : 0;
      sink_idle_pct = (p < 2) ? 45 : (p < 4) ? 11 : 0;
      case (p)
        0:       count_setting = CNT_W'(SLOTS);
        1:       count_setting = '0;
        2:       count_setting = '1;
        3:       count_setting = CNT_W'(1);
        4:       count_setting = CNT_W'($urandom_range(SLOTS - 1, 2));
        default: count_setting = CNT_W'(SLOTS);
      endcase
      set_count(count_setting);
      if (p == 5) begin
        load_table(1'b0);
      end
      random_burst(PHASE_ITEMS);
    end

    settle();
    if (fault_total == 0 && awaited_total == 0) begin
      $display("utf8_to_gbk_transcoder: match");
    end else begin
      $display("utf8_to_gbk_transcoder: mismatch");
    end
    $finish;
  end

endmodule

### utf8_to_gbk_transcoder.f
+incdir+sv
sv/u2g_pkg.sv
sv/u2g_ram.sv
sv/utf8_to_gbk_transcoder.sv
verif/gbk_stream_checker.sv
verif/testbench.sv
